// ===== rtl/tfpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfpt_pkg: shared types and constants of the touch pressure tracker
// Word layouts, converter channel tags, register indexes, unit handshake.
// ----------------------------------------------------------------------------
package tfpt_pkg;

  localparam int VAL_W   = 12;
  localparam int WORD_W  = 16;
  localparam int TAG_W   = 4;
  localparam int ACC_W   = 32;
  localparam int CNT_W   = 5;
  localparam int CFG_IDX_W = 4;

  // converter channel tags
  localparam logic [TAG_W-1:0] TAG_X  = 4'd0;
  localparam logic [TAG_W-1:0] TAG_Y  = 4'd1;
  localparam logic [TAG_W-1:0] TAG_Z1 = 4'd2;
  localparam logic [TAG_W-1:0] TAG_Z2 = 4'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PLATE_OHMS    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 4'd1;

  localparam logic [WORD_W-1:0] PLATE_OHMS_RST    = 16'd400;
  localparam logic [WORD_W-1:0] RELEASE_TICKS_RST = 16'd100;

  localparam logic [ACC_W-1:0] ROUND_ADD = 32'd2047;

  // last step index of each serial phase
  localparam logic [CNT_W-1:0] MUL1_LAST = 5'd11;
  localparam logic [CNT_W-1:0] MUL2_LAST = 5'd15;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd31;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic              start;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z1;
    logic [VAL_W-1:0]  z2;
    logic [WORD_W-1:0] ohms;
  } calc_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             ok;
    logic [VAL_W-1:0] pressure;
  } calc_stat_t;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] pos_x;
    logic [VAL_W-1:0] pos_y;
    logic [VAL_W-1:0] pressure;
    logic             touch_began;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/tfpt_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfpt_intf: valid/ready channels of the touch pressure tracker
// Input frame/tick channel, result channel, register write channel.
// ----------------------------------------------------------------------------
interface tfpt_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [15:0] word_d;
  modport source (output valid, op, word_a, word_b, word_c, word_d, input ready);
  modport sink   (input valid, op, word_a, word_b, word_c, word_d, output ready);
endinterface

interface tfpt_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [11:0] pressure;
  logic        touch_began;
  modport source (output valid, kind, pos_x, pos_y, pressure, touch_began, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pressure, touch_began, output ready);
endinterface

interface tfpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/touch_frame_pressure_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_frame_pressure_tracker_unit: resistive touch pressure and pen-up
// Decodes four tagged converter words, computes pressure bit-serially,
// reports touch points and releases after a pen-up countdown of ticks.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  in_ch   | in  | op, word_a..word_d (frame or tick)
//  out_ch  | out | kind, pos_x, pos_y, pressure, touch_began
//  cfg_ch  | in  | index, data (0 plate_ohms, 1 release_ticks)
//
//  A frame runs 12 + 16 multiply and 32 divide steps of the serial
//  pressure unit and a finish step; only the finish step if Y or Z1 is 0.
//  Reset: plate_ohms 400, release_ticks 100, not touching, countdown idle.
//  A finished word waits in the output register while the next item is
//  taken; a second result parks until it frees, and the input stalls.
// ----------------------------------------------------------------------------
module touch_frame_pressure_tracker_unit (
  input  wire          clk,
  input  wire          rst_n,
  tfpt_in_if.sink      in_ch,
  tfpt_out_if.source   out_ch,
  tfpt_cfg_if.sink     cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] ohms_r, ohms_nxt;
  logic [15:0] rel_ticks_r, rel_ticks_nxt;
  logic        touching_r, touching_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic        armed_r, armed_nxt;

  tfpt_pkg::result_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  tfpt_pkg::result_t pend_r, pend_nxt;

  logic [11:0] x_r, x_nxt;
  logic [11:0] y_r, y_nxt;

  tfpt_pkg::calc_ctl_t  ctl;
  tfpt_pkg::calc_stat_t stat;

  logic [15:0] words [4];
  logic [11:0] ch_x, ch_y, ch_z1, ch_z2;
  logic        in_acc;
  logic        out_free;
  logic        emit;
  tfpt_pkg::result_t res;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  // frame decode: later words with the same tag win, unknown tags dropped
  assign words[0] = in_ch.word_a;
  assign words[1] = in_ch.word_b;
  assign words[2] = in_ch.word_c;
  assign words[3] = in_ch.word_d;

  always_comb begin
    ch_x  = '0;
    ch_y  = '0;
    ch_z1 = '0;
    ch_z2 = '0;
    for (int i = 0; i < 4; i++) begin
      case (words[i][15:12])
        tfpt_pkg::TAG_X:  ch_x  = words[i][11:0];
        tfpt_pkg::TAG_Y:  ch_y  = words[i][11:0];
        tfpt_pkg::TAG_Z1: ch_z1 = words[i][11:0];
        tfpt_pkg::TAG_Z2: ch_z2 = words[i][11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.start = in_acc && (in_ch.op == tfpt_pkg::OP_FRAME);
    ctl.y     = ch_y;
    ctl.z1    = ch_z1;
    ctl.z2    = ch_z2;
    ctl.ohms  = ohms_r;
  end

  tfpt_pressure u_pressure (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .stat  (stat)
  );

  always_comb begin
    state_nxt     = state_r;
    ohms_nxt      = ohms_r;
    rel_ticks_nxt = rel_ticks_r;
    touching_nxt  = touching_r;
    countdown_nxt = countdown_r;
    armed_nxt     = armed_r;
    pend_nxt      = pend_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    emit          = 1'b0;
    res           = '0;

    // register writes must arrive only while idle; the user keeps this, the block leaves it unchecked
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        tfpt_pkg::CFG_PLATE_OHMS:    ohms_nxt      = cfg_ch.data;
        tfpt_pkg::CFG_RELEASE_TICKS: rel_ticks_nxt = cfg_ch.data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.op == tfpt_pkg::OP_TICK) begin
            if (armed_r) begin
              if (countdown_r <= 16'd1) begin
                countdown_nxt = '0;
                armed_nxt     = 1'b0;
                touching_nxt  = 1'b0;
                emit          = 1'b1;
                res.kind      = tfpt_pkg::KIND_RELEASE;
              end else begin
                countdown_nxt = countdown_r - 16'd1;
              end
            end
          end else begin
            // every frame rearms the pen-up countdown
            countdown_nxt = rel_ticks_r;
            armed_nxt     = 1'b1;
            x_nxt         = ch_x;
            y_nxt         = ch_y;
            state_nxt     = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (stat.done) begin
          state_nxt = S_IDLE;
          if (stat.ok) begin
            emit            = 1'b1;
            res.kind        = tfpt_pkg::KIND_POINT;
            res.pos_x       = x_r;
            res.pos_y       = y_r;
            res.pressure    = stat.pressure;
            res.touch_began = !touching_r;
            touching_nxt    = 1'b1;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // new result: straight to the output register, else park it
    if (emit) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        pend_nxt  = res;
        state_nxt = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ohms_r      <= tfpt_pkg::PLATE_OHMS_RST;
      rel_ticks_r <= tfpt_pkg::RELEASE_TICKS_RST;
      touching_r  <= 1'b0;
      countdown_r <= '0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ohms_r      <= ohms_nxt;
      rel_ticks_r <= rel_ticks_nxt;
      touching_r  <= touching_nxt;
      countdown_r <= countdown_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.pos_x       = out_r.pos_x;
  assign out_ch.pos_y       = out_r.pos_y;
  assign out_ch.pressure    = out_r.pressure;
  assign out_ch.touch_began = out_r.touch_began;

`ifndef SYNTHESIS
  // a parked result always sits behind a full output register
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD) |-> out_valid_r)
    else $error("parked result without full output register");

  // countdown is cleared whenever it is not armed
  a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (countdown_r == '0))
    else $error("countdown nonzero while disarmed");

  // pressure unit finishes only for a frame in flight
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == S_CALC))
    else $error("pressure unit done outside calc");

  // no new item while the pressure unit is still busy
  a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !stat.busy)
    else $error("input ready while pressure unit busy");
`endif

endmodule
`default_nettype wire

// ===== rtl/tfpt_pressure.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfpt_pressure: bit-serial pressure unit
// ((z2-z1)*y*ohms/z1 + 2047) >> 12 mod 2^32: two shift-add multiplies and a
// restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module tfpt_pressure (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire tfpt_pkg::calc_ctl_t   ctl,
  output tfpt_pkg::calc_stat_t       stat
);

  typedef enum logic [4:0] {
    P_IDLE = 5'b00001,
    P_MUL1 = 5'b00010,
    P_MUL2 = 5'b00100,
    P_DIV  = 5'b01000,
    P_FIN  = 5'b10000
  } phase_t;

  phase_t phase_r, phase_nxt;

  logic [tfpt_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [tfpt_pkg::ACC_W-1:0]  mcand_r, mcand_nxt;
  logic [tfpt_pkg::WORD_W-1:0] mult_r, mult_nxt;
  logic [tfpt_pkg::ACC_W-1:0]  quo_r, quo_nxt;
  logic [tfpt_pkg::VAL_W-1:0]  rem_r, rem_nxt;
  logic [tfpt_pkg::VAL_W-1:0]  z1_r, z1_nxt;
  logic [tfpt_pkg::WORD_W-1:0] ohms_r, ohms_nxt;
  logic [tfpt_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [tfpt_pkg::ACC_W-1:0]  acc_step;
  logic [tfpt_pkg::VAL_W:0]    trial;
  logic [tfpt_pkg::ACC_W-1:0]  rounded;

  assign acc_step = mult_r[0] ? acc_r + mcand_r : acc_r;
  assign trial    = {rem_r, quo_r[tfpt_pkg::ACC_W-1]};
  assign rounded  = quo_r + tfpt_pkg::ROUND_ADD;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    z1_nxt    = z1_r;
    ohms_nxt  = ohms_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r)
      P_IDLE: begin
        if (ctl.start) begin
          z1_nxt   = ctl.z1;
          ohms_nxt = ctl.ohms;
          if ((ctl.y == '0) || (ctl.z1 == '0)) begin
            // no pressure: rounding of zero gives zero
            quo_nxt   = '0;
            phase_nxt = P_FIN;
          end else begin
            mcand_nxt = {20'b0, ctl.z2} - {20'b0, ctl.z1};
            mult_nxt  = {4'b0, ctl.y};
            acc_nxt   = '0;
            cnt_nxt   = tfpt_pkg::MUL1_LAST;
            phase_nxt = P_MUL1;
          end
        end
      end
      P_MUL1: begin
        acc_nxt   = acc_step;
        mcand_nxt = {mcand_r[tfpt_pkg::ACC_W-2:0], 1'b0};
        mult_nxt  = {1'b0, mult_r[tfpt_pkg::WORD_W-1:1]};
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          mcand_nxt = acc_step;
          mult_nxt  = ohms_r;
          acc_nxt   = '0;
          cnt_nxt   = tfpt_pkg::MUL2_LAST;
          phase_nxt = P_MUL2;
        end
      end
      P_MUL2: begin
        acc_nxt   = acc_step;
        mcand_nxt = {mcand_r[tfpt_pkg::ACC_W-2:0], 1'b0};
        mult_nxt  = {1'b0, mult_r[tfpt_pkg::WORD_W-1:1]};
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          quo_nxt   = acc_step;
          rem_nxt   = '0;
          cnt_nxt   = tfpt_pkg::DIV_LAST;
          phase_nxt = P_DIV;
        end
      end
      P_DIV: begin
        // remainder stays below z1, so 12 bits hold it
        if (trial >= {1'b0, z1_r}) begin
          rem_nxt = tfpt_pkg::VAL_W'(trial - {1'b0, z1_r});
          quo_nxt = {quo_r[tfpt_pkg::ACC_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[tfpt_pkg::VAL_W-1:0];
          quo_nxt = {quo_r[tfpt_pkg::ACC_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          phase_nxt = P_FIN;
        end
      end
      P_FIN: begin
        phase_nxt = P_IDLE;
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    z1_r    <= z1_nxt;
    ohms_r  <= ohms_nxt;
    cnt_r   <= cnt_nxt;
  end

  // usable pressure: nonzero and at most 12 bits
  assign stat.busy     = (phase_r != P_IDLE);
  assign stat.done     = (phase_r == P_FIN);
  assign stat.ok       = (rounded[31:24] == '0) && (rounded[23:12] != '0);
  assign stat.pressure = rounded[23:12];

endmodule
`default_nettype wire
